[sv/hmr_pkg.sv]
package hmr_pkg;

   localparam int REPORT_BYTES = 64;
   localparam int MAX_PAYLOAD  = 7609;
   localparam int POS_W        = $clog2(REPORT_BYTES);
   localparam int LEN_W        = 13;
   localparam int CHAN_W       = 32;
   localparam int CMD_W        = 7;
   localparam int SEQ_W        = 8;
   localparam int BYTE_W       = 8;
   localparam int EV_W         = 3;
   localparam int WIRE_LEN_W   = 2 * BYTE_W;

   localparam logic [POS_W-1:0] POS_CMD    = POS_W'(4);
   localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(5);
   localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(6);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(REPORT_BYTES - 1);
   localparam logic [POS_W:0]   POS_LIMIT  = (POS_W + 1)'(REPORT_BYTES);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

   localparam int INIT_FLAG_BIT = 7;

   typedef enum logic [1:0] {
      KIND_HEAD,
      KIND_SKIP,
      KIND_INIT,
      KIND_CONT
   } kind_type;

   typedef enum logic [EV_W-1:0] {
      EV_PROGRESS,
      EV_COMPLETE,
      EV_LENGTH_ERROR,
      EV_SEQ_DROP,
      EV_IGNORED
   } event_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      kind_type          kind;
      logic              msg_open;
      logic [LEN_W-1:0]  decl_len;
      logic [LEN_W-1:0]  rcv_count;
      logic [SEQ_W-1:0]  exp_seq;
      logic [CHAN_W-1:0] open_chan;
      logic [CMD_W-1:0]  open_cmd;
      logic [CHAN_W-1:0] hdr_chan;
      logic [CMD_W-1:0]  hdr_cmd;
      logic [BYTE_W-1:0] hdr_len_hi;
      event_type         skip_event;
   } state_type;

   typedef struct packed {
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  payload_offset;
      logic              report_done;
      logic [EV_W-1:0]   event_res;
      logic [CHAN_W-1:0] channel_id;
      logic [CMD_W-1:0]  command;
      logic [LEN_W-1:0]  message_length;
   } result_type;

endpackage

[sv/hmr_channels.sv]
interface hmr_req_if import hmr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              report_start;

   modport source (output valid, output data_byte, output report_start, input ready);
   modport sink   (input valid, input data_byte, input report_start, output ready);
endinterface

interface hmr_rsp_if import hmr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              payload_valid;
   logic [BYTE_W-1:0] payload_byte;
   logic [LEN_W-1:0]  payload_offset;
   logic              report_done;
   logic [EV_W-1:0]   event_res;
   logic [CHAN_W-1:0] channel_id;
   logic [CMD_W-1:0]  command;
   logic [LEN_W-1:0]  message_length;

   modport source (
      output valid, output payload_valid, output payload_byte, output payload_offset,
      output report_done, output event_res, output channel_id, output command,
      output message_length, input ready
   );
   modport sink (
      input valid, input payload_valid, input payload_byte, input payload_offset,
      input report_done, input event_res, input channel_id, input command,
      input message_length, output ready
   );
endinterface

interface hmr_csr_if import hmr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] max_message_length;

   modport source (output valid, output max_message_length, input ready);
   modport sink   (input valid, input max_message_length, output ready);
endinterface

[sv/hmr_step.sv]
module hmr_step import hmr_pkg::*; (
   input  state_type         cur,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              report_start,
   input  logic [LEN_W-1:0]  max_len,
   output state_type         nxt,
   output result_type        res
);

   logic [POS_W-1:0]      pos;
   logic [LEN_W-1:0]      lim;
   logic [WIRE_LEN_W-1:0] wire_len;

   always_comb begin
      lim      = (max_len > MAX_LEN) ? MAX_LEN : max_len;
      nxt      = cur;
      res      = '0;
      wire_len = '0;

      pos = report_start ? '0 : cur.pos;
      if ({1'b0, pos} >= POS_LIMIT) begin
         pos = '0;
      end

      if (pos == '0) begin
         nxt.kind       = KIND_HEAD;
         nxt.skip_event = EV_PROGRESS;
         nxt.hdr_chan   = '0;
         nxt.hdr_cmd    = '0;
         nxt.hdr_len_hi = '0;
      end

      if (pos < POS_CMD) begin
         nxt.hdr_chan[BYTE_W * pos[1:0] +: BYTE_W] = data_byte;
      end else if (pos == POS_CMD) begin
         if (data_byte[INIT_FLAG_BIT]) begin
            nxt.kind    = KIND_INIT;
            nxt.hdr_cmd = data_byte[CMD_W-1:0];
         end else if (!nxt.msg_open) begin
            nxt.kind       = KIND_SKIP;
            nxt.skip_event = EV_IGNORED;
         end else if (data_byte != nxt.exp_seq) begin
            nxt.msg_open   = 1'b0;
            nxt.kind       = KIND_SKIP;
            nxt.skip_event = EV_SEQ_DROP;
         end else begin
            nxt.exp_seq = nxt.exp_seq + SEQ_W'(1);
            nxt.kind    = KIND_CONT;
         end
      end else if (nxt.kind == KIND_INIT && pos == POS_LEN_HI) begin
         nxt.hdr_len_hi = data_byte;
      end else if (nxt.kind == KIND_INIT && pos == POS_LEN_LO) begin
         wire_len = {nxt.hdr_len_hi, data_byte};
         if (wire_len > WIRE_LEN_W'(lim)) begin
            nxt.kind       = KIND_SKIP;
            nxt.skip_event = EV_LENGTH_ERROR;
         end else begin
            nxt.open_chan = nxt.hdr_chan;
            nxt.open_cmd  = nxt.hdr_cmd;
            nxt.decl_len  = wire_len[LEN_W-1:0];
            nxt.rcv_count = '0;
            nxt.exp_seq   = '0;
            nxt.msg_open  = 1'b1;
         end
      end else if (nxt.kind == KIND_INIT || nxt.kind == KIND_CONT) begin
         if (nxt.msg_open && nxt.rcv_count < nxt.decl_len) begin
            res.payload_valid  = 1'b1;
            res.payload_byte   = data_byte;
            res.payload_offset = nxt.rcv_count;
            nxt.rcv_count      = nxt.rcv_count + LEN_W'(1);
         end
      end

      if (pos == POS_LAST) begin
         if (nxt.kind == KIND_INIT || nxt.kind == KIND_CONT) begin
            if (nxt.msg_open && nxt.rcv_count == nxt.decl_len) begin
               res.event_res = EV_COMPLETE;
               nxt.msg_open  = 1'b0;
            end else begin
               res.event_res = EV_PROGRESS;
            end
         end else begin
            res.event_res = nxt.skip_event;
         end
         res.report_done    = 1'b1;
         res.channel_id     = nxt.open_chan;
         res.command        = nxt.open_cmd;
         res.message_length = nxt.decl_len;
      end

      nxt.pos = (pos == POS_LAST) ? '0 : pos + POS_W'(1);
   end

endmodule

[sv/hid_message_reassembler_core.sv]
// A request is captured in the input register; its response is then held in the response register.
// Throughput: one request per cycle, sustained, while the response side keeps up.
// The input register and the response register decouple the two channels.
// Reset (synchronous, active high) empties both registers, clears all message state,
// and sets the length limit to its maximum; the configuration port is always ready.
module hid_message_reassembler_core import hmr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   hmr_req_if.sink  req_port,
   hmr_rsp_if.source rsp_port,
   hmr_csr_if.sink  csr_port
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff;
   state_type         state_ff;
   logic [LEN_W-1:0]  max_len_ff;

   state_type  state_in;
   result_type result_in;
   logic       out_free;
   logic       advance;
   logic       accept;

   hmr_step u_step (
      .cur          (state_ff),
      .data_byte    (in_byte_ff),
      .report_start (in_start_ff),
      .max_len      (max_len_ff),
      .nxt          (state_in),
      .res          (result_in)
   );

   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_port.ready = !in_valid_ff || out_free;
   assign accept         = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         max_len_ff   <= MAX_LEN;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_port.valid) begin
            max_len_ff <= csr_port.max_message_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_port.data_byte;
         in_start_ff <= req_port.report_start;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.payload_valid  = result_ff.payload_valid;
   assign rsp_port.payload_byte   = result_ff.payload_byte;
   assign rsp_port.payload_offset = result_ff.payload_offset;
   assign rsp_port.report_done    = result_ff.report_done;
   assign rsp_port.event_res      = result_ff.event_res;
   assign rsp_port.channel_id     = result_ff.channel_id;
   assign rsp_port.command        = result_ff.command;
   assign rsp_port.message_length = result_ff.message_length;

endmodule
